// File: src/stvs_pkg.sv
// Shared types, widths and helpers for the signed tetrahedron volume accumulator.
// Used by stvs_ctrl, stvs_datapath and the top level; depends on nothing else.
package stvs_pkg;

  localparam int COORD_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int PROD_W     = 2 * FIELD_W;
  localparam int DIFF_W     = PROD_W + 1;
  localparam int TERM_W     = FIELD_W + DIFF_W;
  localparam int FSUM_W     = TERM_W + 1;
  localparam int SUM_W      = 61;
  localparam int VOL_W      = 58;
  localparam int REM_W      = 3;

  // The divide by six walks the magnitude 16 bits at a time from the top.
  localparam int DIV_CHUNK   = 16;
  localparam int DIV_W       = 64;
  localparam int DIV_STEPS   = DIV_W / DIV_CHUNK;
  localparam int DIV_V_W     = REM_W + DIV_CHUNK;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 22;
  localparam int DIV_PROD_W  = DIV_V_W + RECIP_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);

  // This is 2^22 / 6 rounded up. It gives the exact quotient for any step value
  // below 2^21, and a step value never reaches 6 * 2^16.
  localparam logic [RECIP_W-1:0] RECIP6 = RECIP_W'(699051);

  typedef struct packed {
    logic signed [FIELD_W-1:0] ax;
    logic signed [FIELD_W-1:0] ay;
    logic signed [FIELD_W-1:0] az;
    logic signed [FIELD_W-1:0] bx;
    logic signed [FIELD_W-1:0] by;
    logic signed [FIELD_W-1:0] bz;
    logic signed [FIELD_W-1:0] cx;
    logic signed [FIELD_W-1:0] cy;
    logic signed [FIELD_W-1:0] cz;
    logic                      last_face;
  } face_t;

  typedef struct packed {
    logic [VOL_W-1:0] volume;
    logic [REM_W-1:0] volume_remainder;
    logic             overflow;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       sub_en;
    logic       tri_en;
    logic [1:0] tri_sel;
    logic       acc_en;
    logic       acc_first;
    logic       sum_en;
    logic       mag_en;
    logic       div_en;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last_face;
  } dp_status_t;

  // Keeps the low COORD_BITS bits of a coordinate and sign-extends them.
  function automatic logic signed [FIELD_W-1:0] sext_coord(input logic [FIELD_W-1:0] v);
    logic signed [FIELD_W-1:0] shifted;
    shifted = $signed(v << (FIELD_W - COORD_BITS));
    return shifted >>> (FIELD_W - COORD_BITS);
  endfunction

endpackage

// File: src/stvs_datapath.sv
// Datapath: face registers, shared multipliers, running sum with saturation,
// a divide by six in 16-bit steps and the result register. Depends on stvs_pkg.
module stvs_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  stvs_pkg::face_t        face,
  input  stvs_pkg::dp_cmd_t      cmd,
  output stvs_pkg::dp_status_t   status,
  output stvs_pkg::result_t      result
);
  import stvs_pkg::*;

  logic signed [FIELD_W-1:0] a [3];
  logic signed [FIELD_W-1:0] b [3];
  logic signed [FIELD_W-1:0] c [3];
  logic                      last_face;

  logic signed [FIELD_W-1:0] bj, cl, bl, cj, ta;
  logic signed [PROD_W-1:0]  p, q;
  logic signed [DIFF_W-1:0]  d;
  logic signed [TERM_W-1:0]  t;
  logic signed [FSUM_W-1:0]  fsum;
  logic signed [SUM_W-1:0]   running_sum;
  logic                      overflow_seen;
  logic signed [SUM_W:0]     wide_sum;
  logic                      sum_ovf;
  logic signed [SUM_W-1:0]   sum_next;
  logic [SUM_W-1:0]          sum_mag;

  logic [DIV_W-1:0]      div_q;
  logic [REM_W-1:0]      div_rem;
  logic                  div_ovf;
  logic [DIV_V_W-1:0]    div_v;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [DIV_CHUNK-1:0]  div_qc;
  logic [DIV_V_W-1:0]    div_r;
  result_t               result_reg;

  // Term k of the triple product is a[k] * (b[j]*c[l] - b[l]*c[j]).
  always_comb begin
    unique case (cmd.mul_sel)
      2'd0: begin
        bj = b[1]; cl = c[2]; bl = b[2]; cj = c[1];
      end
      2'd1: begin
        bj = b[2]; cl = c[0]; bl = b[0]; cj = c[2];
      end
      default: begin
        bj = b[0]; cl = c[1]; bl = b[1]; cj = c[0];
      end
    endcase
    unique case (cmd.tri_sel)
      2'd0:    ta = a[0];
      2'd1:    ta = a[1];
      default: ta = a[2];
    endcase
  end

  always_comb begin
    wide_sum = (SUM_W + 1)'(running_sum) + (SUM_W + 1)'(fsum);
    sum_ovf  = wide_sum[SUM_W] != wide_sum[SUM_W-1];
    if (!sum_ovf) begin
      sum_next = wide_sum[SUM_W-1:0];
    end else if (wide_sum[SUM_W]) begin
      sum_next = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_next = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  assign sum_mag = running_sum[SUM_W-1] ? $unsigned(-running_sum) : $unsigned(running_sum);

  // One long-division step: the running remainder and the next 16 dividend bits
  // are divided by six through a reciprocal multiply.
  always_comb begin
    div_v    = {div_rem, div_q[DIV_W-1 -: DIV_CHUNK]};
    div_prod = DIV_PROD_W'(div_v) * DIV_PROD_W'(RECIP6);
    div_qc   = div_prod[RECIP_SHIFT +: DIV_CHUNK];
    div_r    = div_v - DIV_V_W'({div_qc, 2'b00}) - DIV_V_W'({div_qc, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a[0] <= sext_coord(face.ax);
      a[1] <= sext_coord(face.ay);
      a[2] <= sext_coord(face.az);
      b[0] <= sext_coord(face.bx);
      b[1] <= sext_coord(face.by);
      b[2] <= sext_coord(face.bz);
      c[0] <= sext_coord(face.cx);
      c[1] <= sext_coord(face.cy);
      c[2] <= sext_coord(face.cz);
      last_face <= face.last_face;
    end
    if (cmd.mul_en) begin
      p <= bj * cl;
      q <= bl * cj;
    end
    if (cmd.sub_en) begin
      d <= DIFF_W'(p) - DIFF_W'(q);
    end
    if (cmd.tri_en) begin
      t <= ta * d;
    end
    if (cmd.acc_en) begin
      fsum <= cmd.acc_first ? FSUM_W'(t) : fsum + FSUM_W'(t);
    end
    if (cmd.mag_en) begin
      div_q   <= {{(DIV_W - SUM_W){1'b0}}, sum_mag};
      div_rem <= '0;
      div_ovf <= overflow_seen;
    end else if (cmd.div_en) begin
      // Quotient chunks shift in from the bottom as dividend chunks leave the top.
      div_rem <= div_r[REM_W-1:0];
      div_q   <= {div_q[DIV_W-DIV_CHUNK-1:0], div_qc};
    end
    if (cmd.out_load) begin
      result_reg.volume           <= div_q[VOL_W-1:0];
      result_reg.volume_remainder <= div_rem;
      result_reg.overflow         <= div_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.sum_en) begin
      running_sum <= sum_next;
      if (sum_ovf) begin
        overflow_seen <= 1'b1;
      end
    end else if (cmd.mag_en) begin
      running_sum   <= '0;
      overflow_seen <= 1'b0;
    end
  end

  assign status.last_face = last_face;
  assign result           = result_reg;

endmodule

// File: src/stvs_ctrl.sv
// Controller: sequences the multiply schedule for each face, the divide on the
// last face, and the result handshake. Depends on stvs_pkg.
module stvs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  face_valid,
  output logic                  face_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  output stvs_pkg::dp_cmd_t     cmd,
  input  stvs_pkg::dp_status_t  status
);
  import stvs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_MAG  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [2:0] STEP_SUB   = 3'd1;
  localparam logic [2:0] STEP_TRI   = 3'd2;
  localparam logic [2:0] STEP_MULE  = 3'd2;
  localparam logic [2:0] STEP_ACC   = 3'd3;
  localparam logic [2:0] STEP_SUBE  = 3'd3;
  localparam logic [2:0] STEP_TRIE  = 3'd4;
  localparam logic [2:0] STEP_ACCE  = 3'd5;
  localparam logic [2:0] STEP_SUM   = 3'd6;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  logic [2:0]       state, state_next;
  logic [2:0]       step, step_next;
  logic [CNT_W-1:0] div_cnt, div_cnt_next;
  logic             result_valid_next;

  always_comb begin
    cmd               = '0;
    state_next        = state;
    step_next         = step;
    div_cnt_next      = div_cnt;
    result_valid_next = result_valid;
    if (result_valid && result_ready) begin
      result_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (face_valid) begin
          cmd.load   = 1'b1;
          step_next  = '0;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        // The three terms enter on successive steps and flow through multiply, subtract,
        // multiply and accumulate, so the stages overlap.
        cmd.mul_en    = step <= STEP_MULE;
        cmd.mul_sel   = step[1:0];
        cmd.sub_en    = step >= STEP_SUB && step <= STEP_SUBE;
        cmd.tri_en    = step >= STEP_TRI && step <= STEP_TRIE;
        cmd.tri_sel   = 2'(step - STEP_TRI);
        cmd.acc_en    = step >= STEP_ACC && step <= STEP_ACCE;
        cmd.acc_first = step == STEP_ACC;
        cmd.sum_en    = step == STEP_SUM;
        step_next     = step + 3'd1;
        if (step == STEP_SUM) begin
          state_next = status.last_face ? S_MAG : S_IDLE;
        end
      end
      S_MAG: begin
        cmd.mag_en   = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = S_OUT;
        end else begin
          div_cnt_next = div_cnt + 1'b1;
        end
      end
      S_OUT: begin
        if (!result_valid || result_ready) begin
          cmd.out_load      = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      div_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      step         <= step_next;
      div_cnt      <= div_cnt_next;
      result_valid <= result_valid_next;
    end
  end

  assign face_ready = state == S_IDLE;

endmodule

// File: src/signed_tetrahedron_volume_sum.sv
// Accumulates signed tetrahedron volumes (triple products) of oriented faces and
// reports |sum| / 6 with remainder and a saturation flag on each last face. A face
// request is captured and then runs through the schedule of the two shared 16x16
// multipliers and the 16x33 multiplier that forms the three terms and adds them
// into the saturating 61-bit sum. A last face then forms the magnitude, runs the
// divide by six (16 bits per cycle through a 19x20 reciprocal multiply) and loads
// the result register, waiting as needed for that register to drain; a new face
// is accepted while a result still waits there.
// Depends on stvs_pkg, stvs_ctrl and stvs_datapath.
module signed_tetrahedron_volume_sum (
  input  logic              clk,
  input  logic              rst,
  input  logic              face_valid,
  output logic              face_ready,
  input  stvs_pkg::face_t   face,
  output logic              result_valid,
  input  logic              result_ready,
  output stvs_pkg::result_t result
);
  import stvs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  stvs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .face_valid   (face_valid),
    .face_ready   (face_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

  stvs_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .face   (face),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for signed_tetrahedron_volume_sum: a queue-fed driver, a monitor
// with a saturating volume predictor, random idling on both sides, and a watchdog.
// Depends on stvs_pkg and the top level of the block.
`timescale 1ns / 1ps

module testbench;

  import stvs_pkg::*;

  localparam int    CW               = FIELD_W;
  localparam int    VW               = VOL_W;
  localparam int    RW               = REM_W;
  localparam longint SUM_HI          = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
  localparam longint SUM_LO          = -SUM_HI - 64'sd1;
  localparam longint VOLUME_DIVISOR  = 64'sd6;
  localparam int    RESET_CYCLES     = 8;
  localparam int    IDLE_PCT         = 58;
  localparam int    BOTH_IDLE_PCT    = 6;
  localparam int    PRESSURE_HOLD    = 400;
  localparam int    PRESSURE_FACES   = 30;
  localparam int    RANDOM_PER_PHASE = 420;
  localparam int    DRAIN_CYCLES     = 100;
  localparam int    WATCHDOG_LIMIT   = 5000;
  localparam int    MAX_POS          = 32767;
  localparam int    MAX_NEG          = -32768;

  typedef enum {PH_QUIET, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH_IDLE, PH_PRESSURE} phase_t;
  typedef enum {CS_FULL, CS_SMALL, CS_EXTREME} coord_style_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } vertex_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    face_valid   = 1'b0;
  logic    face_ready;
  face_t   face         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  face_t   pending_faces[$];
  result_t expected_volumes[$];
  phase_t  cur_phase     = PH_QUIET;
  longint  volume_sum    = 0;
  logic    sum_saturated = 1'b0;
  int      mismatch_count = 0;
  int      hold_left     = PRESSURE_HOLD;
  int      stall_cycles  = 0;
  result_t want;

  signed_tetrahedron_volume_sum u_dut (
    .clk          (clk),
    .rst          (rst),
    .face_valid   (face_valid),
    .face_ready   (face_ready),
    .face         (face),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic longint coord_value(logic [CW-1:0] raw);
    longint v;
    v = longint'(raw[COORD_BITS-1:0]);
    if (raw[COORD_BITS-1]) begin
      v -= (64'sd1 <<< COORD_BITS);
    end
    return v;
  endfunction

  function automatic void accumulate_face(face_t f);
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    longint det, s, mag, quot, rem;
    result_t r;
    ax = coord_value(f.ax); ay = coord_value(f.ay); az = coord_value(f.az);
    bx = coord_value(f.bx); by = coord_value(f.by); bz = coord_value(f.bz);
    cx = coord_value(f.cx); cy = coord_value(f.cy); cz = coord_value(f.cz);
    det = ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz) + az * (bx * cy - by * cx);
    s = volume_sum + det;
    if (s > SUM_HI) begin
      s = SUM_HI;
      sum_saturated = 1'b1;
    end else if (s < SUM_LO) begin
      s = SUM_LO;
      sum_saturated = 1'b1;
    end
    volume_sum = s;
    if (f.last_face) begin
      mag  = (s < 0) ? -s : s;
      quot = mag / VOLUME_DIVISOR;
      rem  = mag % VOLUME_DIVISOR;
      r.volume           = quot[VW-1:0];
      r.volume_remainder = rem[RW-1:0];
      r.overflow         = sum_saturated;
      expected_volumes.insert(expected_volumes.size(), r);
      volume_sum    = 0;
      sum_saturated = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic void queue_face(face_t f);
    pending_faces.insert(pending_faces.size(), f);
  endfunction

  function automatic vertex_t vtx(int x, int y, int z);
    vertex_t v;
    v.x = x[CW-1:0];
    v.y = y[CW-1:0];
    v.z = z[CW-1:0];
    return v;
  endfunction

  function automatic face_t make_face(vertex_t a, vertex_t b, vertex_t c, logic last);
    face_t f;
    f.ax = a.x; f.ay = a.y; f.az = a.z;
    f.bx = b.x; f.by = b.y; f.bz = b.z;
    f.cx = c.x; f.cy = c.y; f.cz = c.z;
    f.last_face = last;
    return f;
  endfunction

  function automatic int rand_coord(coord_style_t style);
    int picks[7] = '{MAX_NEG, MAX_NEG + 1, -1, 0, 1, MAX_POS - 1, MAX_POS};
    case (style)
      CS_FULL:  return int'($urandom_range(65535));
      CS_SMALL: return int'($urandom_range(600)) - 300;
      default:  return picks[$urandom_range(6)];
    endcase
  endfunction

  function automatic vertex_t rand_vertex(coord_style_t style);
    return vtx(rand_coord(style), rand_coord(style), rand_coord(style));
  endfunction

  function automatic coord_style_t rand_style();
    return coord_style_t'($urandom_range(2));
  endfunction

  // Either a closed tetrahedron with outward-consistent faces or a loose run of faces.
  task automatic add_random_polyhedron(output int count);
    vertex_t corner[4];
    coord_style_t style;
    int n;
    style = rand_style();
    if ($urandom_range(3) == 0) begin
      for (int i = 0; i < 4; i++) corner[i] = rand_vertex(style);
      queue_face(make_face(corner[1], corner[2], corner[3], 1'b0));
      queue_face(make_face(corner[0], corner[3], corner[2], 1'b0));
      queue_face(make_face(corner[0], corner[1], corner[3], 1'b0));
      queue_face(make_face(corner[0], corner[2], corner[1], 1'b1));
      count = 4;
    end else begin
      n = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
        queue_face(make_face(rand_vertex(rand_style()), rand_vertex(rand_style()),
                             rand_vertex(rand_style()), i == n - 1));
      end
      count = n;
    end
  endtask

  task automatic enter_phase(phase_t p);
    @(negedge clk);
    cur_phase = p;
  endtask

  task automatic wait_drained();
    while (pending_faces.size() != 0 || face_valid || expected_volumes.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random_phase(phase_t p);
    int added;
    int n;
    enter_phase(p);
    added = 0;
    while (added < RANDOM_PER_PHASE) begin
      add_random_polyhedron(n);
      added += n;
    end
    wait_drained();
  endtask

  function automatic int send_idle_pct(phase_t p);
    case (p)
      PH_SEND_IDLE: return IDLE_PCT;
      PH_BOTH_IDLE: return BOTH_IDLE_PCT;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(phase_t p);
    case (p)
      PH_RECV_STALL: return IDLE_PCT;
      PH_BOTH_IDLE:  return BOTH_IDLE_PCT;
      default:       return 0;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- driver and receiver

  always @(posedge clk) begin
    if (rst) begin
      face_valid <= 1'b0;
    end else if (!face_valid || face_ready) begin
      if (pending_faces.size() != 0 && $urandom_range(99) >= send_idle_pct(cur_phase)) begin
        face       <= pending_faces.pop_front();
        face_valid <= 1'b1;
      end else begin
        face_valid <= 1'b0;
      end
    end
  end

  // The long hold-off in the pressure phase lets results pile up until the input stalls.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (cur_phase == PH_PRESSURE && hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct(cur_phase));
    end
  end

  // ---------------------------------------------------------------- monitor and watchdog

  always @(posedge clk) begin
    if (!rst) begin
      if (face_valid && face_ready) begin
        accumulate_face(face);
      end
      if (result_valid && result_ready) begin
        if (expected_volumes.size() == 0) begin
          report_mismatch("result arrived with no expected volume pending");
        end else begin
          want = expected_volumes.pop_front();
          if (result.volume !== want.volume)
            report_mismatch($sformatf("volume got %0d want %0d", result.volume, want.volume));
          if (result.volume_remainder !== want.volume_remainder)
            report_mismatch($sformatf("volume_remainder got %0d want %0d",
                                      result.volume_remainder, want.volume_remainder));
          if (result.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %0b want %0b",
                                      result.overflow, want.overflow));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (face_valid && face_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin
    vertex_t mmm, mmp, mpm, zero_v;
    int k;
    mmm    = vtx(MAX_NEG, MAX_NEG, MAX_NEG);
    mmp    = vtx(MAX_NEG, MAX_NEG, MAX_POS);
    mpm    = vtx(MAX_NEG, MAX_POS, MAX_NEG);
    zero_v = vtx(0, 0, 0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed faces: zero, a closed corner tetrahedron of side 256, extreme coordinates and
    // every remainder of the divide by six, on both signs of the sum.
    enter_phase(PH_QUIET);
    queue_face(make_face(zero_v, zero_v, zero_v, 1'b1));
    queue_face(make_face(vtx(256, 0, 0), vtx(0, 256, 0), vtx(0, 0, 256), 1'b0));
    queue_face(make_face(zero_v, vtx(0, 0, 256), vtx(0, 256, 0), 1'b0));
    queue_face(make_face(zero_v, vtx(256, 0, 0), vtx(0, 0, 256), 1'b0));
    queue_face(make_face(zero_v, vtx(0, 256, 0), vtx(256, 0, 0), 1'b1));
    queue_face(make_face(mmm, mmp, mpm, 1'b1));
    queue_face(make_face(mmm, mpm, mmp, 1'b1));
    queue_face(make_face(vtx(MAX_POS, MAX_POS, MAX_POS), vtx(MAX_POS, MAX_NEG, 0),
                         vtx(MAX_NEG, 0, MAX_POS), 1'b1));
    queue_face(make_face(vtx(-1, -1, -1), vtx(MAX_POS, MAX_POS, MAX_POS),
                         vtx(MAX_NEG, MAX_NEG, MAX_NEG), 1'b1));
    for (k = 1; k <= 6; k++) begin
      queue_face(make_face(vtx(k, 0, 0), vtx(0, 1, 0), vtx(0, 0, 1), 1'b1));
    end
    queue_face(make_face(vtx(-11, 0, 0), vtx(0, 1, 0), vtx(0, 0, 1), 1'b1));
    queue_face(make_face(vtx(-3, 0, 0), vtx(0, 1, 0), vtx(0, 0, 1), 1'b0));
    queue_face(make_face(vtx(5, 0, 0), vtx(0, 1, 0), vtx(0, 0, 1), 1'b1));
    wait_drained();

    // Back-to-back single-face polyhedra against a receiver that holds off.
    enter_phase(PH_PRESSURE);
    for (k = 0; k < PRESSURE_FACES; k++) begin
      queue_face(make_face(rand_vertex(CS_FULL), rand_vertex(CS_FULL),
                           rand_vertex(CS_FULL), 1'b1));
    end
    wait_drained();

    run_random_phase(PH_QUIET);
    run_random_phase(PH_SEND_IDLE);
    run_random_phase(PH_RECV_STALL);
    run_random_phase(PH_BOTH_IDLE);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
src/stvs_pkg.sv
src/stvs_datapath.sv
src/stvs_ctrl.sv
src/signed_tetrahedron_volume_sum.sv
verif/testbench.sv
